// ===== sv/lux_pkg.sv =====
package lux_pkg;

    localparam int unsigned LOG_FRAC_BITS_DEF = 12;
    localparam int unsigned PIX_W             = 8;
    localparam int unsigned Q30_SHIFT         = 30;
    localparam int unsigned P_W               = Q30_SHIFT + 1;
    localparam int unsigned RCP_SHIFT         = 27;
    localparam int unsigned RCP_W             = 27;
    localparam int unsigned NUM_W             = 17;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] red;
    } rb_t;

    typedef struct packed {
        logic [PIX_W-1:0] x_chroma;
        logic [PIX_W-1:0] u_chroma;
        logic [PIX_W-1:0] lum;
    } lux_t;

    // Bitwise integer square root, floor.
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = x;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // log2(v) with frac fraction bits, mantissa refined by repeated squaring.
    function automatic logic [63:0] log2_fix(input int v, input int frac);
        logic [63:0] y;
        logic [63:0] val;
        int          n;
        n = 0;
        for (int m = 0; m < 31; m++) begin
            if ((v >> (m + 1)) != 0) n = m + 1;
        end
        val = 64'(n) << frac;
        y   = (64'(v) << frac) >> n;
        for (int i = 1; i <= 20; i++) begin
            if (i <= frac) begin
                y = (y * y) >> frac;
                if (y >= (64'd2 << frac)) begin
                    y   = y >> 1;
                    val = val | (64'd1 << (frac - i));
                end
            end
        end
        return val;
    endfunction

    // Q30 value of 2^(2^-i): i successive truncated square roots of 2.
    function automatic logic [63:0] exp_root(input int i);
        logic [63:0] r;
        r = 64'd2 << Q30_SHIFT;
        for (int n = 1; n <= 20; n++) begin
            if (n <= i) r = isqrt64(r << Q30_SHIFT);
        end
        return r;
    endfunction

endpackage

// ===== sv/lux_log_sum.sv =====
module lux_log_sum import lux_pkg::*; #(
    parameter int unsigned LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_vld,
    input  rgb_t                       in_pix,
    output logic                       out_vld,
    output logic [LOG_FRAC_BITS+3:0]   out_s,
    output rb_t                        out_rb
);

    localparam int unsigned LW      = LOG_FRAC_BITS + 4;
    localparam int unsigned SW      = LOG_FRAC_BITS + 7;
    localparam int unsigned DIV_K   = SW + 4;
    localparam int unsigned DIV_M_W = SW + 2;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(((64'd1 << DIV_K) + 64'd9) / 64'd10);
    localparam int unsigned PW      = SW + DIV_M_W;

    logic [LW-1:0] log_tab [256];

    for (genvar j = 0; j < 256; j++) begin : g_lg
        localparam logic [LW-1:0] LG = LW'(log2_fix(j + 1, LOG_FRAC_BITS));
        assign log_tab[j] = LG;
    end

    logic [LW-1:0] lg_r, lg_g, lg_b;
    logic [SW-1:0] sum_next, sum_reg;
    logic [PW-1:0] prod_next, prod_reg;
    logic          vld1_reg, vld2_reg;
    rb_t           rb1_reg, rb2_reg;

    // Weighted sum 3*lr + 6*lg + lb; the divide by ten is a reciprocal multiply.
    always_comb begin
        lg_r     = log_tab[in_pix.red];
        lg_g     = log_tab[in_pix.green];
        lg_b     = log_tab[in_pix.blue];
        sum_next = (SW'(lg_r) << 1) + SW'(lg_r) + (SW'(lg_g) << 2) + (SW'(lg_g) << 1)
                 + SW'(lg_b);
        prod_next = PW'(sum_reg) * PW'(DIV_M);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg  <= sum_next;
            rb1_reg  <= '{blue: in_pix.blue, red: in_pix.red};
            prod_reg <= prod_next;
            rb2_reg  <= rb1_reg;
        end
    end

    assign out_vld = vld2_reg;
    assign out_s   = prod_reg[DIV_K +: LW];
    assign out_rb  = rb2_reg;

endmodule

// ===== sv/lux_exp2.sv =====
module lux_exp2 import lux_pkg::*; #(
    parameter int unsigned LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_vld,
    input  logic [LOG_FRAC_BITS+3:0]   in_s,
    input  rb_t                        in_rb,
    output logic                       out_vld,
    output logic [PIX_W-1:0]           out_lum,
    output rb_t                        out_rb
);

    localparam int unsigned F  = LOG_FRAC_BITS;
    localparam int unsigned KW = 4;
    localparam int unsigned VW = 10;
    localparam int unsigned TW = P_W + 9;

    logic           vld_reg [1:F];
    logic [P_W-1:0] p_reg  [1:F];
    logic [KW-1:0]  k_reg  [1:F];
    logic [F-1:0]   f_reg  [1:F];
    rb_t            rb_reg [1:F];

    // One root multiply per fraction bit, most significant bit first.
    for (genvar i = 1; i <= F; i++) begin : g_stage
        localparam logic [P_W-1:0] ROOT = P_W'(exp_root(i));

        logic           v_src;
        logic [P_W-1:0] p_src;
        logic [KW-1:0]  k_src;
        logic [F-1:0]   f_src;
        rb_t            rb_src;
        logic [2*P_W-1:0] prod;
        logic [P_W-1:0] p_next;

        if (i == 1) begin : g_first
            assign v_src  = in_vld;
            assign p_src  = P_W'(64'd1 << Q30_SHIFT);
            assign k_src  = in_s[F +: KW];
            assign f_src  = in_s[F-1:0];
            assign rb_src = in_rb;
        end else begin : g_rest
            assign v_src  = vld_reg[i-1];
            assign p_src  = p_reg[i-1];
            assign k_src  = k_reg[i-1];
            assign f_src  = f_reg[i-1];
            assign rb_src = rb_reg[i-1];
        end

        always_comb begin
            prod   = (2*P_W)'(p_src) * (2*P_W)'(ROOT);
            p_next = f_src[F-i] ? prod[Q30_SHIFT +: P_W] : p_src;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                p_reg[i]  <= p_next;
                k_reg[i]  <= k_src;
                f_reg[i]  <= f_src;
                rb_reg[i] <= rb_src;
            end
        end
    end

    logic [TW-1:0]    scaled;
    logic [VW-1:0]    v_int;
    logic [PIX_W-1:0] lum_next, lum_reg;
    logic             vld_o_reg;
    rb_t              rb_o_reg;

    // Apply the integer part, hold L+1 to 1..256, then L to a byte.
    always_comb begin
        scaled = TW'(p_reg[F]) << k_reg[F];
        v_int  = scaled[Q30_SHIFT +: VW];
        if (k_reg[F] > KW'(8)) begin
            lum_next = PIX_W'(255);
        end else if (v_int == '0) begin
            lum_next = '0;
        end else if (v_int >= VW'(256)) begin
            lum_next = PIX_W'(255);
        end else begin
            lum_next = PIX_W'(v_int - VW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o_reg <= 1'b0;
        end else if (adv) begin
            vld_o_reg <= vld_reg[F];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lum_reg  <= lum_next;
            rb_o_reg <= rb_reg[F];
        end
    end

    assign out_vld = vld_o_reg;
    assign out_lum = lum_reg;
    assign out_rb  = rb_o_reg;

`ifndef ASSERT_OFF
    a_p_at_least_one: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[F] |-> p_reg[F][Q30_SHIFT])
        else $error("exp2 product fell below one");
    a_int_part_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[F] |-> (k_reg[F] <= KW'(8)))
        else $error("exp2 integer part above eight");
`endif

endmodule

// ===== sv/lux_chroma.sv =====
module lux_chroma import lux_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [PIX_W-1:0] in_lum,
    input  rb_t              in_rb,
    output logic             out_vld,
    output lux_t             out_lux
);

    localparam int unsigned PRD_W = NUM_W + RCP_W;

    logic [RCP_W-1:0] rcp_tab [256];

    // ceil(2^26 / (j+1)), the reciprocal of 2*(j+1) scaled by 2^27.
    for (genvar j = 0; j < 256; j++) begin : g_rcp
        localparam logic [RCP_W-1:0] RCP =
            RCP_W'(((64'd1 << (RCP_SHIFT - 1)) + 64'(j)) / 64'(j + 1));
        assign rcp_tab[j] = RCP;
    end

    logic             vld_a_reg, vld_b_reg, vld_c_reg;
    logic [PIX_W-1:0] lum_a_reg, lum_b_reg;
    logic             lt_a_reg [2];
    logic             lt_b_reg [2];
    logic [NUM_W-1:0] num_reg  [2];
    logic [RCP_W-1:0] rcp_reg  [2];
    logic [PRD_W-1:0] prod_reg [2];
    logic [NUM_W-1:0] q_w      [2];
    logic [PIX_W-1:0] res_w    [2];
    lux_t             lux_reg;

    // Lane 0 is red (U), lane 1 is blue (X).
    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [PIX_W-1:0] c_in;
        logic [PIX_W:0]   c1, l1;
        logic             lt_next;
        logic [PIX_W-1:0] idx;
        logic [NUM_W-1:0] num_next;

        assign c_in = (g == 0) ? in_rb.red : in_rb.blue;

        always_comb begin
            c1      = (PIX_W + 1)'(c_in) + 1'b1;
            l1      = (PIX_W + 1)'(in_lum) + 1'b1;
            lt_next = c_in < in_lum;
            if (lt_next) begin
                idx      = in_lum;
                num_next = (NUM_W'(c1) << 8) - NUM_W'(c1);
            end else begin
                // Round the quotient up: add divisor minus one.
                idx      = c_in;
                num_next = (NUM_W'(l1) << 8) - NUM_W'(l1) + (NUM_W'(c1) << 1) - NUM_W'(1);
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                lt_a_reg[g]  <= lt_next;
                num_reg[g]   <= num_next;
                rcp_reg[g]   <= rcp_tab[idx];
                prod_reg[g]  <= PRD_W'(num_reg[g]) * PRD_W'(rcp_reg[g]);
                lt_b_reg[g]  <= lt_a_reg[g];
            end
        end

        always_comb begin
            q_w[g] = prod_reg[g][RCP_SHIFT +: NUM_W];
            if (lt_b_reg[g]) begin
                res_w[g] = q_w[g][PIX_W-1:0];
            end else if (q_w[g] > NUM_W'(255)) begin
                res_w[g] = '0;
            end else begin
                res_w[g] = PIX_W'(255) - q_w[g][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lum_a_reg <= in_lum;
            lum_b_reg <= lum_a_reg;
            lux_reg   <= '{x_chroma: res_w[1], u_chroma: res_w[0], lum: lum_b_reg};
        end
    end

    assign out_vld = vld_c_reg;
    assign out_lux = lux_reg;

`ifndef ASSERT_OFF
    a_u_low_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_b_reg && lt_b_reg[0]) |-> (q_w[0] < NUM_W'(128)))
        else $error("U quotient out of range for channel below L");
    a_x_low_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_b_reg && lt_b_reg[1]) |-> (q_w[1] < NUM_W'(128)))
        else $error("X quotient out of range for channel below L");
`endif

endmodule

// ===== sv/rgb_to_lux_pixel_converter.sv =====
// RGB to LUX pixel converter: one 8-bit RGB pixel in, one LUX pixel (lum, u_chroma,
// x_chroma) out, one result per pixel, accepting a pixel every clock while the output
// is not stalled. The pipeline registers, in order, the log table lookup and weighted
// sum, the divide by ten, each step of the 2^x root-multiply chain over the fraction
// bits, the scaling and clamping of L, then the chroma reciprocal operands, product
// and result. The whole pipeline advances together; a stall on the output holds every
// stage, and s_tready drops only while a finished beat waits on m_tready or while
// aresetn is held low.
module rgb_to_lux_pixel_converter import lux_pkg::*; #(
    parameter int unsigned LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // lum [7:0], u_chroma [15:8], x_chroma [23:16]
);

    localparam int unsigned LW = LOG_FRAC_BITS + 4;

    logic             adv;
    rgb_t             pix;
    logic             sum_vld, lum_vld, out_vld;
    logic [LW-1:0]    s_val;
    rb_t              sum_rb, lum_rb;
    logic [PIX_W-1:0] lum;
    lux_t             lux;

    // Advance when the output beat is empty or being taken.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && aresetn;
    assign pix      = rgb_t'(s_tdata);

    lux_log_sum #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_log_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .in_pix  (pix),
        .out_vld (sum_vld),
        .out_s   (s_val),
        .out_rb  (sum_rb)
    );

    lux_exp2 #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_exp2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (sum_vld),
        .in_s    (s_val),
        .in_rb   (sum_rb),
        .out_vld (lum_vld),
        .out_lum (lum),
        .out_rb  (lum_rb)
    );

    lux_chroma u_chroma (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (lum_vld),
        .in_lum  (lum),
        .in_rb   (lum_rb),
        .out_vld (out_vld),
        .out_lux (lux)
    );

    assign m_tvalid = out_vld;
    assign m_tdata  = 24'(lux);

endmodule
